@@ rtl/fei_pkg.sv @@
// shared types, widths and register codes for the escape-time fractal iterator
// no dependencies; compiled first
package fei_pkg;

   // fixed widths of the number format and the register port
   localparam int VAL_WIDTH       = 32;
   localparam int PROD_WIDTH      = 64;
   localparam int STEP_WIDTH      = 31;
   localparam int MODE_WIDTH      = 2;
   localparam int LIMIT_WIDTH     = 12;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_ADDR_WIDTH  = 5;
   localparam int REG_INDEX_WIDTH = 3;

   // parameter defaults for the top level
   localparam int COORD_WIDTH_DEF = 12;
   localparam int ITER_WIDTH_DEF  = 12;
   localparam int FRAC_BITS_DEF   = 28;

   typedef logic signed [VAL_WIDTH-1:0]  val_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic [MODE_WIDTH-1:0]        mode_type;
   typedef logic [REG_INDEX_WIDTH-1:0]   reg_index_type;

   // saturation bounds of a coordinate, held wide
   localparam prod_type VAL_MAX_WIDE = (prod_type'(1) <<< (VAL_WIDTH - 1)) - prod_type'(1);
   localparam prod_type VAL_MIN_WIDE = -(prod_type'(1) <<< (VAL_WIDTH - 1));

   // fractal modes
   localparam mode_type MODE_MANDELBROT = 2'd0;
   localparam mode_type MODE_JULIA      = 2'd1;
   localparam mode_type MODE_JULIA_ABS  = 2'd2;

   // register indexes
   localparam reg_index_type REG_FRACTAL_MODE    = 3'd0;
   localparam reg_index_type REG_PIXEL_STEP      = 3'd1;
   localparam reg_index_type REG_CENTER_REAL     = 3'd2;
   localparam reg_index_type REG_CENTER_IMAG     = 3'd3;
   localparam reg_index_type REG_JULIA_REAL      = 3'd4;
   localparam reg_index_type REG_JULIA_IMAG      = 3'd5;
   localparam reg_index_type REG_ITERATION_LIMIT = 3'd6;

   // register reset values
   localparam logic [STEP_WIDTH-1:0]  PIXEL_STEP_RESET      = 31'd1342177;
   localparam logic [LIMIT_WIDTH-1:0] ITERATION_LIMIT_RESET = 12'd64;

   // configuration as seen by the core
   typedef struct packed {
      mode_type                fractal_mode;
      logic [STEP_WIDTH-1:0]   pixel_step;
      val_type                 center_real;
      val_type                 center_imag;
      val_type                 julia_real;
      val_type                 julia_imag;
      logic [LIMIT_WIDTH-1:0]  iteration_limit;
   } cfg_type;

endpackage

@@ rtl/fei_req_if.sv @@
// pixel word channel: valid/ready handshake with the pixel coordinate pair
// standalone interface, no package needed
interface fei_req_if #(
   parameter int COORD_WIDTH = 12
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] pixel_x;
   logic signed [COORD_WIDTH-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ rtl/fei_rsp_if.sv @@
// result word channel: valid/ready handshake with the iteration count
// standalone interface, no package needed
interface fei_rsp_if #(
   parameter int ITER_WIDTH = 12
);
   logic                  valid;
   logic                  ready;
   logic [ITER_WIDTH-1:0] iteration_count;

   modport source (output valid, output iteration_count, input ready);
   modport sink   (input valid, input iteration_count, output ready);
endinterface

@@ rtl/fei_csr.sv @@
// configuration registers behind an apb-style port
// depends on fei_pkg
module fei_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fei_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [fei_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [fei_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready,
   output fei_pkg::cfg_type                    cfg
);
   import fei_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign pready = 1'b1;
   assign index  = paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_FRACTAL_MODE:    cfg_in.fractal_mode    = pwdata[MODE_WIDTH-1:0];
            REG_PIXEL_STEP:      cfg_in.pixel_step      = pwdata[STEP_WIDTH-1:0];
            REG_CENTER_REAL:     cfg_in.center_real     = signed'(pwdata);
            REG_CENTER_IMAG:     cfg_in.center_imag     = signed'(pwdata);
            REG_JULIA_REAL:      cfg_in.julia_real      = signed'(pwdata);
            REG_JULIA_IMAG:      cfg_in.julia_imag      = signed'(pwdata);
            REG_ITERATION_LIMIT: cfg_in.iteration_limit = pwdata[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // register read mux
   always_comb begin
      case (index)
         REG_FRACTAL_MODE:    prdata = CSR_DATA_WIDTH'(cfg_ff.fractal_mode);
         REG_PIXEL_STEP:      prdata = CSR_DATA_WIDTH'(cfg_ff.pixel_step);
         REG_CENTER_REAL:     prdata = unsigned'(cfg_ff.center_real);
         REG_CENTER_IMAG:     prdata = unsigned'(cfg_ff.center_imag);
         REG_JULIA_REAL:      prdata = unsigned'(cfg_ff.julia_real);
         REG_JULIA_IMAG:      prdata = unsigned'(cfg_ff.julia_imag);
         REG_ITERATION_LIMIT: prdata = CSR_DATA_WIDTH'(cfg_ff.iteration_limit);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{fractal_mode:    MODE_MANDELBROT,
                     pixel_step:      PIXEL_STEP_RESET,
                     center_real:     '0,
                     center_imag:     '0,
                     julia_real:      '0,
                     julia_imag:      '0,
                     iteration_limit: ITERATION_LIMIT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/fei_mul.sv @@
// shared signed 32x32 multiplier with registered 64-bit product
// depends on fei_pkg
module fei_mul (
   input  logic              clock,
   input  fei_pkg::val_type  mul_a,
   input  fei_pkg::val_type  mul_b,
   output fei_pkg::prod_type mul_p
);
   import fei_pkg::*;

   prod_type prod_ff;
   prod_type prod_in;

   // exact product, operands sign-extended by context
   assign prod_in = mul_a * mul_b;
   assign mul_p   = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ rtl/fei_core.sv @@
// sequencer and datapath: pixel mapping and the z = z*z + c loop on one multiplier
// depends on fei_pkg, fei_req_if, fei_rsp_if
module fei_core #(
   parameter int COORD_WIDTH = fei_pkg::COORD_WIDTH_DEF,
   parameter int ITER_WIDTH  = fei_pkg::ITER_WIDTH_DEF,
   parameter int FRAC_BITS   = fei_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  fei_pkg::cfg_type  cfg,
   fei_req_if.sink           req,
   fei_rsp_if.source         rsp,
   output fei_pkg::val_type  mul_a,
   output fei_pkg::val_type  mul_b,
   input  fei_pkg::prod_type mul_p
);
   import fei_pkg::*;

   localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MAP    = 8'b0000_0010,
      ST_INIT   = 8'b0000_0100,
      ST_SQ_RE  = 8'b0000_1000,
      ST_SQ_IM  = 8'b0001_0000,
      ST_CROSS  = 8'b0010_0000,
      ST_UPDATE = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   function automatic val_type sat_val(input prod_type v);
      if (v > VAL_MAX_WIDE) begin
         return VAL_WIDTH'(VAL_MAX_WIDE);
      end else if (v < VAL_MIN_WIDE) begin
         return VAL_WIDTH'(VAL_MIN_WIDE);
      end
      return VAL_WIDTH'(v);
   endfunction

   state_type                     state_ff, state_in;
   logic signed [COORD_WIDTH-1:0] py_ff, py_in;
   val_type                       pr_ff, pr_in;
   val_type                       zr_ff, zr_in;
   val_type                       zi_ff, zi_in;
   val_type                       cr_ff, cr_in;
   val_type                       ci_ff, ci_in;
   prod_type                      rr_ff, rr_in;
   prod_type                      ii_ff, ii_in;
   logic [ITER_WIDTH-1:0]         n_ff, n_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ITER_WIDTH-1:0]         count_ff, count_in;

   logic [ITER_WIDTH-1:0]         limit;
   val_type                       step_val;
   val_type                       pi_val;
   val_type                       neg_pr;
   val_type                       upd_re;
   val_type                       upd_im;
   logic [PROD_WIDTH-1:0]         mag_sum;
   logic                          escaped;
   logic                          rsp_free;
   logic                          load_rsp;

   assign limit    = ITER_WIDTH'(cfg.iteration_limit);
   assign step_val = signed'({1'b0, cfg.pixel_step});

   // mapped imaginary part, product of py and step is on the multiplier output
   assign pi_val = sat_val(mul_p + prod_type'(cfg.center_imag));
   assign neg_pr = sat_val(-prod_type'(pr_ff));

   // escape test: rr is registered, ii is on the multiplier output
   assign mag_sum = unsigned'(rr_ff) + unsigned'(mul_p);
   assign escaped = (mag_sum >> ESC_SHIFT) != '0;

   // next z: real from squares, imaginary from cross product on the multiplier output
   assign upd_re = sat_val(((rr_ff - ii_ff) >>> FRAC_BITS) + prod_type'(cr_ff));
   assign upd_im = sat_val((mul_p >>> (FRAC_BITS - 1)) + prod_type'(ci_ff));

   // output register handshake
   assign rsp_free            = !rsp_valid_ff || rsp.ready;
   assign load_rsp            = (state_ff == ST_FINISH) && rsp_free;
   assign rsp_valid_in        = load_rsp || (rsp_valid_ff && !rsp.ready);
   assign count_in            = load_rsp ? n_ff : count_ff;
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.iteration_count = count_ff;
   assign req.ready           = (state_ff == ST_IDLE);

   // multiplier operand select
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            mul_a = val_type'(req.pixel_x);
            mul_b = step_val;
         end
         ST_MAP: begin
            mul_a = val_type'(py_ff);
            mul_b = step_val;
         end
         ST_SQ_RE: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         ST_SQ_IM: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      py_in    = py_ff;
      pr_in    = pr_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      rr_in    = rr_ff;
      ii_in    = ii_ff;
      n_in     = n_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               py_in    = req.pixel_y;
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            pr_in    = sat_val(mul_p + prod_type'(cfg.center_real));
            state_in = ST_INIT;
         end
         ST_INIT: begin
            n_in = '0;
            if (cfg.fractal_mode == MODE_MANDELBROT) begin
               zr_in = '0;
               zi_in = '0;
               cr_in = pr_ff;
               ci_in = pi_val;
            end else begin
               zr_in = (cfg.fractal_mode == MODE_JULIA_ABS && pr_ff < 0) ? neg_pr : pr_ff;
               zi_in = pi_val;
               cr_in = cfg.julia_real;
               ci_in = cfg.julia_imag;
            end
            state_in = ST_SQ_RE;
         end
         ST_SQ_RE: begin
            state_in = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            rr_in    = mul_p;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            ii_in = mul_p;
            if (escaped || n_ff >= limit) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            zr_in    = upd_re;
            zi_in    = upd_im;
            n_in     = ITER_WIDTH'(n_ff + 1'b1);
            state_in = ST_SQ_RE;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      py_ff    <= py_in;
      pr_ff    <= pr_in;
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      rr_ff    <= rr_in;
      ii_ff    <= ii_in;
      n_ff     <= n_in;
      count_ff <= count_in;
   end

endmodule

@@ rtl/escape_time_fractal_iterator_top.sv @@
// Escape-time fractal iterator (Mandelbrot, Julia, Julia with |Re z0|) in signed fixed
// point with FRAC_BITS fraction bits in 32-bit coordinates. Each pixel word is mapped to
// the plane as pixel * pixel_step + center and z = z*z + c is iterated while |z|^2 < 4 and
// the count is below iteration_limit; one result word carries the count. All products go
// through a single registered 32x32 multiplier, three per iteration; an iteration steps through
// the states SQ_RE, SQ_IM, CROSS and UPDATE in that order. One pixel is worked at a time;
// the result sits in an output register, so a new pixel may be accepted before it is taken.
// depends on fei_pkg, fei_req_if, fei_rsp_if, fei_csr, fei_mul, fei_core
module escape_time_fractal_iterator_top #(
   parameter int COORD_WIDTH = fei_pkg::COORD_WIDTH_DEF,
   parameter int ITER_WIDTH  = fei_pkg::ITER_WIDTH_DEF,
   parameter int FRAC_BITS   = fei_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   fei_req_if.sink                            req_chan,
   fei_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fei_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [fei_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [fei_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);
   import fei_pkg::*;

   cfg_type  cfg;
   val_type  mul_a;
   val_type  mul_b;
   prod_type mul_p;

   // configuration registers
   fei_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // shared multiplier
   fei_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // iteration sequencer
   fei_core #(
      .COORD_WIDTH (COORD_WIDTH),
      .ITER_WIDTH  (ITER_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_chan),
      .rsp   (rsp_chan),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

endmodule
